>>> rtl/core/seven_segment_display_writer_top_macros.svh
// Assertion helpers shared by the display writer RTL.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef SEVEN_SEGMENT_DISPLAY_WRITER_TOP_MACROS_SVH
`define SEVEN_SEGMENT_DISPLAY_WRITER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSDW_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSDW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/ssdw_pkg.sv
package ssdw_pkg;

   // Command codes.
   localparam logic [1:0] CMD_CONTROL = 2'd0;
   localparam logic [1:0] CMD_SET     = 2'd1;
   localparam logic [1:0] CMD_SHOW    = 2'd2;
   localparam logic [1:0] CMD_CLEAR   = 2'd3;

   // Configuration register indexes.
   localparam logic REG_BRIGHTNESS = 1'b0;
   localparam logic REG_ENABLE     = 1'b1;

   // Bus addresses.
   localparam logic [7:0] CTRL_ADDR  = 8'h48;
   localparam logic [7:0] DIGIT_BASE = 8'h68;

   // Digit positions up to seven fit in three bits; wider positions are truncated to them.
   localparam int POS_W = 3;

   // Microprogram step addresses.
   localparam int PC_W = 3;
   localparam logic [PC_W-1:0] STEP_IDLE      = 3'd0;
   localparam logic [PC_W-1:0] STEP_CTRL      = 3'd1;
   localparam logic [PC_W-1:0] STEP_SET_CHK   = 3'd2;
   localparam logic [PC_W-1:0] STEP_SET       = 3'd3;
   localparam logic [PC_W-1:0] STEP_CLEAR     = 3'd4;
   localparam logic [PC_W-1:0] STEP_NUM_CHK   = 3'd5;
   localparam logic [PC_W-1:0] STEP_NUM       = 3'd6;

   typedef struct packed {
      logic [1:0]  command;
      logic [1:0]  digit_index;
      logic        eight_segment;
      logic [15:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] bus_address;
      logic [7:0] bus_data;
      logic       last_frame;
   } rsp_type;

   // Control word fields.
   typedef enum logic [2:0] {
      EMIT_NONE, EMIT_CTRL, EMIT_SET, EMIT_CLEAR, EMIT_NUM
   } emit_type;

   typedef enum logic [2:0] {
      COND_ALWAYS, COND_POS_BAD, COND_CLR_MORE, COND_NUM_GO, COND_NUM_MORE
   } cond_type;

   typedef enum logic [1:0] {
      LAST_NONE, LAST_ALWAYS, LAST_CLEAR, LAST_NUM
   } last_type;

   typedef enum logic [2:0] {
      CNT_HOLD, CNT_ZERO, CNT_INC, CNT_TOP, CNT_DEC
   } cnt_type;

   typedef struct packed {
      logic            dispatch;
      emit_type        emit;
      cond_type        cond;
      last_type        last;
      cnt_type         cnt;
      logic [PC_W-1:0] next_t;
      logic [PC_W-1:0] next_f;
   } uword_type;

   // Microprogram ROM. A step jumps to next_t when its condition holds,
   // otherwise to next_f.
   function automatic uword_type ssdw_ucode(logic [PC_W-1:0] pc);
      uword_type uw;
      unique case (pc)
         STEP_CTRL:    uw = '{1'b0, EMIT_CTRL, COND_ALWAYS, LAST_ALWAYS, CNT_HOLD,
                              STEP_IDLE, STEP_IDLE};
         STEP_SET_CHK: uw = '{1'b0, EMIT_NONE, COND_POS_BAD, LAST_NONE, CNT_HOLD,
                              STEP_IDLE, STEP_SET};
         STEP_SET:     uw = '{1'b0, EMIT_SET, COND_ALWAYS, LAST_ALWAYS, CNT_HOLD,
                              STEP_IDLE, STEP_IDLE};
         STEP_CLEAR:   uw = '{1'b0, EMIT_CLEAR, COND_CLR_MORE, LAST_CLEAR, CNT_INC,
                              STEP_CLEAR, STEP_NUM_CHK};
         STEP_NUM_CHK: uw = '{1'b0, EMIT_NONE, COND_NUM_GO, LAST_NONE, CNT_TOP,
                              STEP_NUM, STEP_IDLE};
         STEP_NUM:     uw = '{1'b0, EMIT_NUM, COND_NUM_MORE, LAST_NUM, CNT_DEC,
                              STEP_NUM, STEP_IDLE};
         default:      uw = '{1'b1, EMIT_NONE, COND_ALWAYS, LAST_NONE, CNT_ZERO,
                              STEP_IDLE, STEP_IDLE};
      endcase
      return uw;
   endfunction

   // First step of each command.
   function automatic logic [PC_W-1:0] ssdw_entry(logic [1:0] command);
      logic [PC_W-1:0] pc;
      unique case (command)
         CMD_CONTROL: pc = STEP_CTRL;
         CMD_SET:     pc = STEP_SET_CHK;
         default:     pc = STEP_CLEAR;
      endcase
      return pc;
   endfunction

   // Seven-segment pattern of a decimal digit; codes above nine are blank.
   function automatic logic [7:0] ssdw_seg7(logic [3:0] d);
      logic [7:0] p;
      case (d)
         4'd0:    p = 8'h3F;
         4'd1:    p = 8'h06;
         4'd2:    p = 8'h5B;
         4'd3:    p = 8'h4F;
         4'd4:    p = 8'h66;
         4'd5:    p = 8'h6D;
         4'd6:    p = 8'h7D;
         4'd7:    p = 8'h07;
         4'd8:    p = 8'h7F;
         4'd9:    p = 8'h6F;
         default: p = 8'h00;
      endcase
      return p;
   endfunction

   // Eight-segment pattern, which adds the point segment.
   function automatic logic [7:0] ssdw_seg8(logic [3:0] d);
      logic [7:0] p;
      case (d)
         4'd0:    p = 8'hBF;
         4'd1:    p = 8'h86;
         4'd2:    p = 8'hDB;
         4'd3:    p = 8'hCF;
         4'd4:    p = 8'hE6;
         4'd5:    p = 8'hED;
         4'd6:    p = 8'hFD;
         4'd7:    p = 8'h87;
         4'd8:    p = 8'hFF;
         4'd9:    p = 8'hEF;
         default: p = 8'h00;
      endcase
      return p;
   endfunction

   // Pattern for a full 16-bit digit value; ten and above is blank.
   function automatic logic [7:0] ssdw_pattern(logic [15:0] v, logic eight);
      logic [7:0] p;
      if (v >= 16'd10) begin
         p = 8'h00;
      end else if (eight) begin
         p = ssdw_seg8(v[3:0]);
      end else begin
         p = ssdw_seg7(v[3:0]);
      end
      return p;
   endfunction

   // Bus address of a digit position.
   function automatic logic [7:0] ssdw_digit_addr(logic [POS_W-1:0] pos);
      return DIGIT_BASE + {4'b0000, pos, 1'b0};
   endfunction

endpackage

>>> rtl/core/ssdw_div10.sv
module ssdw_div10 (
   input  logic [15:0] dividend,
   output logic [12:0] quotient,
   output logic [3:0]  remainder
);
   logic [31:0] product;
   logic [15:0] tenfold;
   logic [15:0] diff;

   // Reciprocal multiply: (x * 0xCCCD) >> 19 is exact for any 16-bit x.
   assign product  = dividend * 16'hCCCD;
   assign quotient = product[31:19];

   // Remainder by subtracting ten times the quotient (shift and add).
   assign tenfold   = {quotient, 3'b000} + {2'b00, quotient, 1'b0};
   assign diff      = dividend - tenfold;
   assign remainder = diff[3:0];
endmodule

>>> rtl/core/seven_segment_display_writer_top.sv
// Frames leave through the output register on rsp_*; set first checks its digit position.
// The microprogram runs one step per cycle, except while rsp_stall holds a frame.
// Control emits one frame, set one if its position is below DIGIT_COUNT, and clear one
// per digit; show number clears every digit, then writes one frame per shown digit.
// One command is in flight at a time; the next beat is taken once the sequencer is idle again.
// Reset (synchronous, active high) zeroes both registers and returns the sequencer to idle.
module seven_segment_display_writer_top #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ssdw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ssdw_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [2:0]       csr_wdata
);
   import ssdw_pkg::*;
   `include "seven_segment_display_writer_top_macros.svh"

   localparam int CNT_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGIT_COUNT - 1);

   // Smallest power of ten that does not fit, capped once it passes 16 bits.
   function automatic int limit_of(int dc);
      int lim;
      lim = 1;
      for (int i = 0; i < dc; i++) begin
         if (lim <= 65535) begin
            lim = lim * 10;
         end
      end
      return lim;
   endfunction

   localparam logic [16:0] SHOW_LIMIT = 17'(limit_of(DIGIT_COUNT));

   // Configuration registers.
   logic [2:0] brightness_ff;
   logic       enable_ff;

   // Sequencer and command state.
   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       pos_ff;
   logic             eight_ff;
   logic [15:0]      rest_ff, rest_in;
   logic             num_go_ff;

   // Output register.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   uword_type   uw;
   logic        emit_en;
   logic        out_free;
   logic        step_go;
   logic        cond_hit;
   logic        pos_bad;
   logic        clr_more;
   logic        num_more;
   logic        rsp_load;
   logic        req_take;
   logic        num_go_in;
   logic [12:0] quotient;
   logic [3:0]  remainder;
   logic [7:0]  ctrl_byte;

   ssdw_div10 u_div10 (
      .dividend  (rest_ff),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= 3'd0;
         enable_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_BRIGHTNESS: brightness_ff <= csr_wdata;
            default:        enable_ff     <= csr_wdata[0];
         endcase
      end
   end

   // Decode the current control word and its branch conditions.
   always_comb begin
      uw        = ssdw_ucode(pc_ff);
      emit_en   = (uw.emit != EMIT_NONE);
      out_free  = !rsp_valid_ff || !rsp_stall;
      req_take  = uw.dispatch && req_valid;
      step_go   = uw.dispatch ? req_valid : (emit_en ? out_free : 1'b1);
      rsp_load  = step_go && emit_en;
      pos_bad   = ({2'b00, pos_ff} >= 4'(DIGIT_COUNT));
      clr_more  = (cnt_ff != CNT_LAST);
      num_more  = (quotient != 13'd0) && (cnt_ff != '0);
      num_go_in = (req_data.command == CMD_SHOW) && (req_data.value != 16'd0) &&
                  ({1'b0, req_data.value} < SHOW_LIMIT);
      case (uw.cond)
         COND_POS_BAD:  cond_hit = pos_bad;
         COND_CLR_MORE: cond_hit = clr_more;
         COND_NUM_GO:   cond_hit = num_go_ff;
         COND_NUM_MORE: cond_hit = num_more;
         default:       cond_hit = 1'b1;
      endcase
   end

   // Next step, digit counter and remaining number.
   always_comb begin
      pc_in   = pc_ff;
      cnt_in  = cnt_ff;
      rest_in = rest_ff;
      if (step_go) begin
         if (uw.dispatch) begin
            pc_in   = ssdw_entry(req_data.command);
            rest_in = req_data.value;
         end else begin
            pc_in = cond_hit ? uw.next_t : uw.next_f;
         end
         case (uw.cnt)
            CNT_ZERO: cnt_in = '0;
            CNT_INC:  cnt_in = cnt_ff + 1'b1;
            CNT_TOP:  cnt_in = CNT_LAST;
            CNT_DEC:  cnt_in = cnt_ff - 1'b1;
            default:  cnt_in = cnt_ff;
         endcase
         if (uw.emit == EMIT_NUM) begin
            rest_in = {3'b000, quotient};
         end
      end
   end

   // Frame contents for the current step.
   always_comb begin
      ctrl_byte = enable_ff ? {1'b0, brightness_ff, 1'b0, !eight_ff, 1'b0, 1'b1} : 8'h00;
      rsp_data_in.bus_address = ssdw_digit_addr(POS_W'(cnt_ff));
      rsp_data_in.bus_data    = 8'h00;
      case (uw.emit)
         EMIT_CTRL: begin
            rsp_data_in.bus_address = CTRL_ADDR;
            rsp_data_in.bus_data    = ctrl_byte;
         end
         EMIT_SET: begin
            rsp_data_in.bus_address = ssdw_digit_addr(POS_W'(pos_ff));
            rsp_data_in.bus_data    = ssdw_pattern(rest_ff, eight_ff);
         end
         EMIT_NUM: begin
            rsp_data_in.bus_data = ssdw_seg7(remainder);
         end
         default: begin
            rsp_data_in.bus_data = 8'h00;
         end
      endcase
      case (uw.last)
         LAST_ALWAYS: rsp_data_in.last_frame = 1'b1;
         LAST_CLEAR:  rsp_data_in.last_frame = !clr_more && !num_go_ff;
         LAST_NUM:    rsp_data_in.last_frame = !num_more;
         default:     rsp_data_in.last_frame = 1'b0;
      endcase
   end

   // Sequencer control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff <= pc_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rest_ff <= rest_in;
      if (req_take) begin
         pos_ff    <= req_data.digit_index;
         eight_ff  <= req_data.eight_segment;
         num_go_ff <= num_go_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign req_stall = !uw.dispatch;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SSDW_ASSERT_NEXT(a_last_returns_idle, rsp_load && rsp_data_in.last_frame, (pc_ff == STEP_IDLE) || (pc_ff == STEP_NUM_CHK && !num_go_ff), "sequencer kept emitting after the last frame")
   `SSDW_ASSERT_SAME(a_num_needs_go, pc_ff == STEP_NUM, num_go_ff, "number digits written for a number that shows nothing")
   `SSDW_ASSERT_SAME(a_num_rest_nonzero, pc_ff == STEP_NUM, rest_ff != 16'd0, "number step entered with nothing left to show")
endmodule

>>> verif/testbench.sv
module testbench;
   import ssdw_pkg::*;

   localparam int DIGITS = 4;
   // Largest shown number plus one: ten to the power of the digit count.
   localparam int SHOW_LIMIT = 10000;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_we;
   logic csr_index;
   logic [2:0] csr_wdata;

   // When set, neither side inserts gaps or stalls.
   bit quiet;

   // Mirrors the two registers and computes the frames that each command yields.
   class display_frame_model;
      logic [2:0] bright_level;
      logic display_on;
      rsp_type expected_frames[$];
      int error_count;
      logic [7:0] seg7[10];
      logic [7:0] seg8[10];

      function new();
         bright_level = '0;
         display_on = 1'b0;
         error_count = 0;
         seg7 = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
         seg8 = '{8'hBF, 8'h86, 8'hDB, 8'hCF, 8'hE6, 8'hED, 8'hFD, 8'h87, 8'hFF, 8'hEF};
      endfunction

      function void set_register(logic idx, logic [2:0] data);
         if (idx == REG_BRIGHTNESS) begin
            bright_level = data;
         end else begin
            display_on = data[0];
         end
      endfunction

      function logic [7:0] digit_address(int pos);
         return DIGIT_BASE + 8'(2 * pos);
      endfunction

      function logic [7:0] segment_pattern(logic [15:0] digit, logic eight);
         if (digit >= 16'd10) begin
            return 8'h00;
         end
         return eight ? seg8[digit[3:0]] : seg7[digit[3:0]];
      endfunction

      function void add_frame(logic [7:0] addr, logic [7:0] data);
         rsp_type f;
         f.bus_address = addr;
         f.bus_data = data;
         f.last_frame = 1'b0;
         expected_frames.push_back(f);
      endfunction

      function void add_blank_digits();
         for (int i = 0; i < DIGITS; i++) begin
            add_frame(digit_address(i), 8'h00);
         end
      endfunction

      // Every command yields at least one frame, so the final one gets the last flag.
      function void note_command(req_type c);
         rsp_type f;
         int rest;
         int pos;
         case (c.command)
            CMD_CONTROL: begin
               if (display_on) begin
                  add_frame(CTRL_ADDR, {1'b0, bright_level, 1'b0, ~c.eight_segment, 2'b01});
               end else begin
                  add_frame(CTRL_ADDR, 8'h00);
               end
            end
            CMD_SET: begin
               add_frame(digit_address(int'(c.digit_index)),
                         segment_pattern(c.value, c.eight_segment));
            end
            CMD_SHOW: begin
               add_blank_digits();
               if (int'(c.value) < SHOW_LIMIT) begin
                  rest = int'(c.value);
                  pos = DIGITS;
                  while (rest != 0 && pos > 0) begin
                     pos--;
                     add_frame(digit_address(pos), segment_pattern(16'(rest % 10), 1'b0));
                     rest = rest / 10;
                  end
               end
            end
            default: begin
               add_blank_digits();
            end
         endcase
         f = expected_frames.pop_back();
         f.last_frame = 1'b1;
         expected_frames.push_back(f);
      endfunction

      function void check_frame(rsp_type got);
         rsp_type want;
         if (expected_frames.size() == 0) begin
            $display("%0t: frame with none expected, actual %h/%h/%b", $time,
                     got.bus_address, got.bus_data, got.last_frame);
            error_count++;
            return;
         end
         want = expected_frames.pop_front();
         if (got.bus_address !== want.bus_address) begin
            $display("%0t: bus_address expected %h actual %h", $time,
                     want.bus_address, got.bus_address);
            error_count++;
         end
         if (got.bus_data !== want.bus_data) begin
            $display("%0t: bus_data expected %h actual %h", $time,
                     want.bus_data, got.bus_data);
            error_count++;
         end
         if (got.last_frame !== want.last_frame) begin
            $display("%0t: last_frame expected %b actual %b", $time,
                     want.last_frame, got.last_frame);
            error_count++;
         end
      endfunction

      function int pending_count();
         return expected_frames.size();
      endfunction
   endclass

   display_frame_model board = new();

   seven_segment_display_writer_top #(
      .DIGIT_COUNT(DIGITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type make_command(logic [1:0] cmd, logic [1:0] idx, logic eight,
                                            logic [15:0] value);
      req_type c;
      c.command = cmd;
      c.digit_index = idx;
      c.eight_segment = eight;
      c.value = value;
      return c;
   endfunction

   function automatic req_type random_command();
      req_type c;
      int r;
      c.digit_index = 2'($urandom_range(0, 3));
      c.eight_segment = 1'($urandom_range(0, 1));
      c.value = 16'($urandom);
      r = $urandom_range(0, 99);
      if (r < 15) begin
         c.command = CMD_CONTROL;
      end else if (r < 45) begin
         c.command = CMD_SET;
      end else if (r < 80) begin
         c.command = CMD_SHOW;
      end else begin
         c.command = CMD_CLEAR;
      end
      r = $urandom_range(0, 99);
      if (c.command == CMD_SET) begin
         if (r < 70) begin
            c.value = 16'($urandom_range(0, 9));
         end else if (r < 85) begin
            c.value = 16'($urandom_range(10, 15));
         end
      end else if (c.command == CMD_SHOW) begin
         if (r < 15) begin
            c.value = 16'($urandom_range(0, 9));
         end else if (r < 35) begin
            c.value = 16'($urandom_range(10, 999));
         end else if (r < 70) begin
            c.value = 16'($urandom_range(1000, 9999));
         end else if (r < 80) begin
            c.value = 16'd0;
         end else if (r < 88) begin
            c.value = 16'($urandom_range(10000, 65535));
         end
      end
      return c;
   endfunction

   // Holds valid until the beat is taken; valid stays high for a back-to-back beat.
   task automatic send_command(req_type c);
      @(negedge clock);
      req_data <= c;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      board.note_command(c);
   endtask

   task automatic idle_sender(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic write_reg(logic idx, logic [2:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      board.set_register(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Waits for every expected frame, then lets the sequencer return to idle.
   task automatic drain_frames();
      idle_sender(1);
      while (board.pending_count() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 25 == 0) begin
            quiet = ($urandom_range(0, 3) == 0);
         end
         send_command(random_command());
         if ($urandom_range(0, 40) == 0) begin
            drain_frames();
         end else begin
            idle_sender(gap_length());
         end
      end
      quiet = 1'b0;
   endtask

   task automatic run_directed();
      send_command(make_command(CMD_CONTROL, 2'd0, 1'b0, 16'h0000));
      send_command(make_command(CMD_CONTROL, 2'd3, 1'b1, 16'hFFFF));
      send_command(make_command(CMD_SET, 2'd0, 1'b0, 16'd0));
      send_command(make_command(CMD_SET, 2'd3, 1'b1, 16'd9));
      send_command(make_command(CMD_SET, 2'd1, 1'b0, 16'd8));
      send_command(make_command(CMD_SET, 2'd2, 1'b1, 16'd1));
      // Digit codes of ten and above are blank.
      send_command(make_command(CMD_SET, 2'd2, 1'b0, 16'd10));
      send_command(make_command(CMD_SET, 2'd1, 1'b1, 16'hFFFF));
      send_command(make_command(CMD_SET, 2'd3, 1'b0, 16'd15));
      // Showing zero leaves only the clearing frames.
      send_command(make_command(CMD_SHOW, 2'd0, 1'b0, 16'd0));
      send_command(make_command(CMD_SHOW, 2'd0, 1'b0, 16'd9999));
      // Numbers beyond the display width only clear it.
      send_command(make_command(CMD_SHOW, 2'd3, 1'b1, 16'd10000));
      send_command(make_command(CMD_SHOW, 2'd2, 1'b0, 16'hFFFF));
      send_command(make_command(CMD_SHOW, 2'd1, 1'b0, 16'd1));
      send_command(make_command(CMD_SHOW, 2'd0, 1'b0, 16'd1000));
      // The point segment never appears in a shown number.
      send_command(make_command(CMD_SHOW, 2'd0, 1'b1, 16'd7));
      send_command(make_command(CMD_SHOW, 2'd2, 1'b1, 16'd4096));
      send_command(make_command(CMD_CLEAR, 2'd0, 1'b0, 16'd0));
      send_command(make_command(CMD_CLEAR, 2'd3, 1'b1, 16'hFFFF));
      idle_sender(1);
   endtask

   // Frames are checked at every rising edge where one is taken.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_frame(rsp_data);
      end
   end

   // Receiver stalls in runs of random length.
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         n = gap_length();
         if (n == 0) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #12000000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [2:0] bright_value;
      logic [2:0] enable_value;
      reset = 1'b1;
      quiet = 1'b0;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = REG_BRIGHTNESS;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_reg(REG_BRIGHTNESS, 3'd7);
      write_reg(REG_ENABLE, 3'd1);
      run_directed();
      drain_frames();

      // Each phase runs under its own register setting, extremes first.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               bright_value = 3'd0;
               enable_value = 3'd1;
            end
            1: begin
               bright_value = 3'd7;
               enable_value = 3'd0;
            end
            2: begin
               bright_value = 3'd3;
               enable_value = 3'b111;
            end
            3: begin
               bright_value = 3'($urandom);
               enable_value = 3'($urandom);
            end
            default: begin
               bright_value = 3'd5;
               enable_value = 3'b110;
            end
         endcase
         if ($urandom_range(0, 1) == 0) begin
            write_reg(REG_BRIGHTNESS, bright_value);
            write_reg(REG_ENABLE, enable_value);
         end else begin
            write_reg(REG_ENABLE, enable_value);
            write_reg(REG_BRIGHTNESS, bright_value);
         end
         run_random(38);
         drain_frames();
      end

      repeat (10) @(posedge clock);
      if (board.error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ssdw_pkg.sv
rtl/core/ssdw_div10.sv
rtl/core/seven_segment_display_writer_top.sv
verif/testbench.sv
